// File: rtl/core/ldfw_pkg.sv
// shared types, constants and microcode rom for the lcd decimal field writer
package ldfw_pkg;

  localparam int MAX_WIDTH = 16;
  localparam int POS_W     = 7;
  localparam int VAL_W     = 31;
  localparam int FW_W      = 5;
  localparam int BYTE_W    = 8;
  localparam int CNT_W     = $clog2(MAX_WIDTH + 1);
  localparam int WCMP_W    = (CNT_W > FW_W) ? CNT_W : FW_W;
  localparam int STEP_W    = 3;

  // reciprocal of ten, q = (v * RECIP10) >> RECIP_SH exact for 32-bit v
  localparam int          RECIP_SH = 35;
  localparam int          PROD_W   = VAL_W + 32;
  localparam int          QUO_W    = PROD_W - RECIP_SH;
  localparam logic [31:0] RECIP10  = 32'hCCCC_CCCD;

  localparam logic [BYTE_W-1:0] CMD_ENTRY_DEC = 8'h04;
  localparam logic [BYTE_W-1:0] CMD_SET_ADDR  = 8'h80;
  localparam logic [BYTE_W-1:0] CHR_ZERO      = 8'h30;
  localparam logic [BYTE_W-1:0] CHR_SPACE     = 8'h20;

  typedef enum logic [1:0] {
    SRC_ENTRY,
    SRC_ADDR,
    SRC_DIGIT,
    SRC_PAD
  } src_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_REQ,
    COND_MORE_DIG,
    COND_FULL,
    COND_MORE_CELLS
  } cond_t;

  typedef struct packed {
    logic              load;
    logic              emit;
    logic              mul;
    logic              last_chk;
    src_t              src;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } cw_t;

  typedef struct packed {
    logic q_zero;
    logic last_cell;
    logic full;
    logic out_busy;
  } dp_status_t;

  localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_ENTRY = 3'd1;
  localparam logic [STEP_W-1:0] STEP_ADDR  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_MUL   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_DIG   = 3'd4;
  localparam logic [STEP_W-1:0] STEP_CHK   = 3'd5;
  localparam logic [STEP_W-1:0] STEP_PAD   = 3'd6;
  localparam logic [STEP_W-1:0] STEP_DONE  = 3'd7;

  // load emit mul last_chk src cond target
  function automatic cw_t ucode_rom(input logic [STEP_W-1:0] step);
    cw_t cw;
    case (step)
      STEP_IDLE:  cw = '{1'b1, 1'b0, 1'b0, 1'b0, SRC_ENTRY, COND_NO_REQ,     STEP_IDLE};
      STEP_ENTRY: cw = '{1'b0, 1'b1, 1'b0, 1'b0, SRC_ENTRY, COND_NEVER,      STEP_IDLE};
      STEP_ADDR:  cw = '{1'b0, 1'b1, 1'b0, 1'b0, SRC_ADDR,  COND_NEVER,      STEP_IDLE};
      STEP_MUL:   cw = '{1'b0, 1'b0, 1'b1, 1'b0, SRC_DIGIT, COND_NEVER,      STEP_IDLE};
      STEP_DIG:   cw = '{1'b0, 1'b1, 1'b0, 1'b1, SRC_DIGIT, COND_MORE_DIG,   STEP_MUL};
      STEP_CHK:   cw = '{1'b0, 1'b0, 1'b0, 1'b0, SRC_PAD,   COND_FULL,       STEP_IDLE};
      STEP_PAD:   cw = '{1'b0, 1'b1, 1'b0, 1'b1, SRC_PAD,   COND_MORE_CELLS, STEP_PAD};
      STEP_DONE:  cw = '{1'b0, 1'b0, 1'b0, 1'b0, SRC_PAD,   COND_ALWAYS,     STEP_IDLE};
      default:    cw = '{1'b0, 1'b0, 1'b0, 1'b0, SRC_PAD,   COND_ALWAYS,     STEP_IDLE};
    endcase
    return cw;
  endfunction

endpackage

// File: rtl/core/ldfw_seq.sv
// microcode sequencer: step counter, control rom and conditional jumps
module ldfw_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  ldfw_pkg::dp_status_t st,
  output ldfw_pkg::cw_t       cw,
  output logic [ldfw_pkg::STEP_W-1:0] step
);

  logic [ldfw_pkg::STEP_W-1:0] step_r;
  logic [ldfw_pkg::STEP_W-1:0] step_nxt;
  logic                        take;
  logic                        hold;

  assign cw   = ldfw_pkg::ucode_rom(step_r);
  assign step = step_r;
  // an emitting step waits while the output register is still full
  assign hold = cw.emit && st.out_busy;

  always_comb begin
    case (cw.cond)
      ldfw_pkg::COND_NEVER:      take = 1'b0;
      ldfw_pkg::COND_ALWAYS:     take = 1'b1;
      ldfw_pkg::COND_NO_REQ:     take = !in_valid;
      ldfw_pkg::COND_MORE_DIG:   take = !st.q_zero && !st.last_cell;
      ldfw_pkg::COND_FULL:       take = st.full;
      ldfw_pkg::COND_MORE_CELLS: take = !st.last_cell;
      default:                   take = 1'b1;
    endcase
    if (hold) begin
      step_nxt = step_r;
    end else if (take) begin
      step_nxt = cw.target;
    end else begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ldfw_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// File: rtl/core/ldfw_dpath.sv
// datapath: request registers, divide-by-ten step, cell counter and output register
module ldfw_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ldfw_pkg::cw_t                 cw,
  input  logic                          in_valid,
  input  logic [ldfw_pkg::POS_W-1:0]    in_start_position,
  input  logic [ldfw_pkg::VAL_W-1:0]    in_value,
  input  logic [ldfw_pkg::FW_W-1:0]     in_field_width,
  input  logic                          in_pad_with_zeros,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_is_data,
  output logic [ldfw_pkg::BYTE_W-1:0]   out_bus_byte,
  output logic                          out_last,
  output ldfw_pkg::dp_status_t          st,
  output logic [ldfw_pkg::CNT_W-1:0]    cnt,
  output logic [ldfw_pkg::CNT_W-1:0]    width
);

  logic [ldfw_pkg::POS_W-1:0]  pos_r;
  logic [ldfw_pkg::VAL_W-1:0]  val_r;
  logic [ldfw_pkg::QUO_W-1:0]  q_r;
  logic [ldfw_pkg::CNT_W-1:0]  w_r;
  logic [ldfw_pkg::CNT_W-1:0]  cnt_r;
  logic                        zeros_r;

  logic                        out_valid_r;
  logic                        out_is_data_r;
  logic [ldfw_pkg::BYTE_W-1:0] out_bus_byte_r;
  logic                        out_last_r;

  logic [ldfw_pkg::WCMP_W-1:0] fw_ext;
  logic [ldfw_pkg::CNT_W-1:0]  w_clamp;
  logic [ldfw_pkg::PROD_W-1:0] prod;
  logic [3:0]                  digit;
  logic [ldfw_pkg::POS_W-1:0]  addr;
  logic [ldfw_pkg::BYTE_W-1:0] byte_sel;
  logic                        load;
  logic                        fire;
  logic                        last_cell;

  assign load = cw.load && in_valid;
  assign fire = cw.emit && !(out_valid_r && !out_ready);

  always_comb begin
    fw_ext = ldfw_pkg::WCMP_W'(in_field_width);
    if (fw_ext == '0) begin
      w_clamp = ldfw_pkg::CNT_W'(1);
    end else if (fw_ext > ldfw_pkg::WCMP_W'(ldfw_pkg::MAX_WIDTH)) begin
      w_clamp = ldfw_pkg::CNT_W'(ldfw_pkg::MAX_WIDTH);
    end else begin
      w_clamp = ldfw_pkg::CNT_W'(fw_ext);
    end
  end

  assign prod = ldfw_pkg::PROD_W'(val_r) * ldfw_pkg::PROD_W'(ldfw_pkg::RECIP10);
  // remainder is below ten, so the low nibble alone settles it
  assign digit = 4'(val_r[3:0] - 4'(q_r[3:0] * 4'd10));
  assign addr  = 7'(pos_r + 7'(w_r) - 7'd1);
  assign last_cell = (ldfw_pkg::CNT_W'(cnt_r + 1'b1) == w_r);

  always_comb begin
    case (cw.src)
      ldfw_pkg::SRC_ENTRY: byte_sel = ldfw_pkg::CMD_ENTRY_DEC;
      ldfw_pkg::SRC_ADDR:  byte_sel = ldfw_pkg::CMD_SET_ADDR | ldfw_pkg::BYTE_W'(addr);
      ldfw_pkg::SRC_DIGIT: byte_sel = ldfw_pkg::CHR_ZERO | ldfw_pkg::BYTE_W'(digit);
      ldfw_pkg::SRC_PAD:   byte_sel = zeros_r ? ldfw_pkg::CHR_ZERO : ldfw_pkg::CHR_SPACE;
      default:             byte_sel = ldfw_pkg::CHR_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pos_r   <= in_start_position;
      val_r   <= in_value;
      zeros_r <= in_pad_with_zeros;
    end else if (fire && cw.src == ldfw_pkg::SRC_DIGIT) begin
      val_r <= ldfw_pkg::VAL_W'(q_r);
    end
    if (cw.mul) begin
      q_r <= prod[ldfw_pkg::PROD_W-1:ldfw_pkg::RECIP_SH];
    end
    out_is_data_r  <= fire ? (cw.src == ldfw_pkg::SRC_DIGIT || cw.src == ldfw_pkg::SRC_PAD)
                           : out_is_data_r;
    out_bus_byte_r <= fire ? byte_sel : out_bus_byte_r;
    out_last_r     <= fire ? (cw.last_chk && last_cell) : out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r         <= ldfw_pkg::CNT_W'(1);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        w_r   <= w_clamp;
        cnt_r <= '0;
      end else if (fire && (cw.src == ldfw_pkg::SRC_DIGIT || cw.src == ldfw_pkg::SRC_PAD)) begin
        cnt_r <= ldfw_pkg::CNT_W'(cnt_r + 1'b1);
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign st.q_zero    = (q_r == '0);
  assign st.last_cell = last_cell;
  assign st.full      = (cnt_r == w_r);
  assign st.out_busy  = out_valid_r && !out_ready;

  assign out_valid    = out_valid_r;
  assign out_is_data  = out_is_data_r;
  assign out_bus_byte = out_bus_byte_r;
  assign out_last     = out_last_r;
  assign cnt          = cnt_r;
  assign width        = w_r;

endmodule

// File: rtl/core/lcd_decimal_field_writer_core.sv
// top level of the lcd decimal field writer: sequencer, datapath and checks
//
// takes one request on the in_ channel (start position, value, field width,
// padding flag) and plays out a run of lcd bus writes on the out_ channel:
// entry-mode decrement command, set-address of the field's rightmost cell,
// the decimal digits least significant first, then padding cells. the final
// write of a run carries out_last. a run is 2 + w writes, w the clamped width.
// in_ready is high only while the sequencer sits at its idle step, so one
// request is in flight at a time; on acceptance the step counter moves to
// the entry step, which loads the first write into the output register.
// each digit passes through a reciprocal-multiply step and then an emit
// step, each padding cell through the pad step alone. a single output
// register holds the pending write, so a stalled receiver freezes the step
// counter at its next emitting step. reset (rst_n low, synchronous) returns
// the sequencer to idle, empties the output register and resets the width
// and cell counter; the other datapath registers are not reset.
module lcd_decimal_field_writer_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ldfw_pkg::POS_W-1:0]  in_start_position,
  input  logic [ldfw_pkg::VAL_W-1:0]  in_value,
  input  logic [ldfw_pkg::FW_W-1:0]   in_field_width,
  input  logic                        in_pad_with_zeros,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_is_data,
  output logic [ldfw_pkg::BYTE_W-1:0] out_bus_byte,
  output logic                        out_last
);

  ldfw_pkg::cw_t                 cw;
  ldfw_pkg::dp_status_t          st;
  logic [ldfw_pkg::STEP_W-1:0]   step;
  logic [ldfw_pkg::CNT_W-1:0]    cnt;
  logic [ldfw_pkg::CNT_W-1:0]    width;

  ldfw_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .cw       (cw),
    .step     (step)
  );

  ldfw_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cw                (cw),
    .in_valid          (in_valid),
    .in_start_position (in_start_position),
    .in_value          (in_value),
    .in_field_width    (in_field_width),
    .in_pad_with_zeros (in_pad_with_zeros),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_is_data       (out_is_data),
    .out_bus_byte      (out_bus_byte),
    .out_last          (out_last),
    .st                (st),
    .cnt               (cnt),
    .width             (width)
  );

  // no request is taken while reset is held
  assign in_ready = cw.load && rst_n;

  // cell counter never runs past the field
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt <= width)
    else $error("cell count beyond field width");

  // clamped width is within range after a request is taken
  a_width_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=>
      (width >= ldfw_pkg::CNT_W'(1) && width <= ldfw_pkg::CNT_W'(ldfw_pkg::MAX_WIDTH)))
    else $error("field width not clamped");

  // character writes are a decimal digit or a space
  a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_data) |->
      ((out_bus_byte[7:4] == 4'h3 && out_bus_byte[3:0] <= 4'd9) ||
       out_bus_byte == ldfw_pkg::CHR_SPACE))
    else $error("bad character byte");

  // requests are only taken at the idle step
  a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (step == ldfw_pkg::STEP_IDLE))
    else $error("request taken outside idle step");

endmodule
